[rtl/core/smi_pkg.sv]
// Shared constants for the symmetric 3x3 matrix inverse core.
package smi_pkg;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned NumCof       = 6;
  localparam int unsigned NumEnt       = 9;
  localparam int unsigned QueueDepth   = 4;
endpackage

[rtl/core/smi_fifo.sv]
// Short queue that decouples the cofactor front from the divider back.
module smi_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = smi_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end
endmodule

[rtl/core/smi_front.sv]
// Front pipeline: cofactors, determinant and their magnitudes and signs.
module smi_front #(
  parameter int unsigned D = smi_pkg::DataWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [D-1:0]  m_i [9],
  input  logic                 full_i,
  output logic                 push_o,
  output logic [6*(2*D+2)+3*D+4:0] data_o
);
  import smi_pkg::*;

  localparam int unsigned PW = 2 * D;
  localparam int unsigned CW = 2 * D + 1;
  localparam int unsigned TW = 3 * D + 3;
  localparam int unsigned EW = CW + 1;

  logic en;
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q;

  logic signed [PW-1:0] pa_q [2*NumCof];
  logic signed [D-1:0]  ra_q [3], rb_q [3];
  logic signed [CW-1:0] cb_q [NumCof], cc_q [NumCof], cd_q [NumCof], ce_q [NumCof];
  logic signed [CW-1:0] cb_d [NumCof];
  logic signed [CW-1:0] pl_q [3], ph_q [3];
  logic signed [TW-1:0] t_q [3], t_d [3];
  logic signed [TW-1:0] det_q;
  logic [CW-1:0]        cmag_q [NumCof];
  logic                 cneg_q [NumCof];
  logic [TW-1:0]        dmag_q;
  logic                 dneg_q, dzero_q;

  assign en         = !full_i;
  assign in_ready_o = en;
  assign push_o     = en && vf_q;

  always_comb begin
    for (int k = 0; k < NumCof; k++) begin
      cb_d[k] = {pa_q[2*k][PW-1], pa_q[2*k]} - {pa_q[2*k+1][PW-1], pa_q[2*k+1]};
    end
    for (int k = 0; k < 3; k++) begin
      t_d[k] = ({{(TW-CW){ph_q[k][CW-1]}}, ph_q[k]} <<< D)
             + {{(TW-CW){pl_q[k][CW-1]}}, pl_q[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q[0]  <= m_i[4] * m_i[8];
      pa_q[1]  <= m_i[5] * m_i[7];
      pa_q[2]  <= m_i[3] * m_i[8];
      pa_q[3]  <= m_i[5] * m_i[6];
      pa_q[4]  <= m_i[3] * m_i[7];
      pa_q[5]  <= m_i[4] * m_i[6];
      pa_q[6]  <= m_i[0] * m_i[8];
      pa_q[7]  <= m_i[2] * m_i[6];
      pa_q[8]  <= m_i[0] * m_i[7];
      pa_q[9]  <= m_i[1] * m_i[6];
      pa_q[10] <= m_i[0] * m_i[4];
      pa_q[11] <= m_i[1] * m_i[3];
      ra_q     <= m_i[0:2];
      cb_q     <= cb_d;
      rb_q     <= ra_q;
      for (int k = 0; k < 3; k++) begin
        pl_q[k] <= rb_q[k] * $signed({1'b0, cb_q[k][D-1:0]});
        ph_q[k] <= rb_q[k] * $signed(cb_q[k][CW-1:D]);
      end
      cc_q  <= cb_q;
      t_q   <= t_d;
      cd_q  <= cc_q;
      det_q <= t_q[0] - t_q[1] + t_q[2];
      ce_q  <= cd_q;
      for (int k = 0; k < NumCof; k++) begin
        cmag_q[k] <= ce_q[k][CW-1] ? CW'(-ce_q[k]) : CW'(ce_q[k]);
        // Cofactors 1 and 4 (counting from zero) enter the inverse negated.
        cneg_q[k] <= ce_q[k][CW-1] ^ ((k == 1) || (k == 4));
      end
      dmag_q  <= det_q[TW-1] ? TW'(-det_q) : TW'(det_q);
      dneg_q  <= det_q[TW-1];
      dzero_q <= (det_q == '0);
    end
  end

  always_comb begin
    for (int k = 0; k < NumCof; k++) begin
      data_o[k*EW +: EW] = {cneg_q[k], cmag_q[k]};
    end
    data_o[NumCof*EW +: TW+2] = {dzero_q, dneg_q, dmag_q};
  end
endmodule

[rtl/core/smi_div.sv]
// One divider lane: restoring division, one quotient bit per stage, with clamp.
module smi_div #(
  parameter int unsigned D = smi_pkg::DataWidthDef,
  parameter int unsigned F = smi_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2*D:0]        c_mag_i,
  input  logic                c_neg_i,
  input  logic [3*D+2:0]      d_mag_i,
  input  logic                d_neg_i,
  output logic signed [D-1:0] q_o,
  output logic                sat_o
);
  localparam int unsigned CW = 2 * D + 1;
  localparam int unsigned TW = 3 * D + 3;
  localparam int unsigned NW = CW + 2 * F;
  localparam int unsigned HW = NW - D;
  localparam int unsigned RW = ((HW > TW) ? HW : TW) + 1;

  logic [NW-1:0] num;
  logic [RW-1:0] rem0;
  logic [RW-1:0] rem_q [D+1];
  logic [D-1:0]  lo_q  [D+1];
  logic [D-1:0]  q_q   [D+1];
  logic [RW-1:0] det_q [D+1];
  logic          ovf_q [D+1];
  logic          neg_q [D+1];

  assign num  = {c_mag_i, {(2*F){1'b0}}};
  assign rem0 = RW'(num[NW-1:D]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0;
      lo_q[0]  <= num[D-1:0];
      q_q[0]   <= '0;
      det_q[0] <= RW'(d_mag_i);
      ovf_q[0] <= (rem0 >= RW'(d_mag_i));
      neg_q[0] <= c_neg_i ^ d_neg_i;
    end
  end

  for (genvar k = 0; k < D; k++) begin : g_stage
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {rem_q[k][RW-2:0], lo_q[k][D-1-k]};
    assign ge = (sh >= det_q[k]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? sh - det_q[k] : sh;
        lo_q[k+1]  <= lo_q[k];
        q_q[k+1]   <= q_q[k] | (D'(ge) << (D - 1 - k));
        det_q[k+1] <= det_q[k];
        ovf_q[k+1] <= ovf_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  logic [D-1:0] q, lim;
  logic         neg, big;

  always_comb begin
    q     = q_q[D];
    lim   = {1'b1, {(D-1){1'b0}}};
    neg   = neg_q[D] && ((q != '0) || ovf_q[D]);
    big   = ovf_q[D] || (neg ? (q > lim) : (q >= lim));
    sat_o = big;
    if (big) begin
      q_o = neg ? $signed(lim) : $signed(~lim);
    end else begin
      q_o = neg ? $signed(-q) : $signed(q);
    end
  end
endmodule

[rtl/core/smi_back.sv]
// Back part: six divider lanes fed from the queue and the output register.
module smi_back #(
  parameter int unsigned D = smi_pkg::DataWidthDef,
  parameter int unsigned F = smi_pkg::FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  logic [6*(2*D+2)+3*D+4:0] q_data_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [D-1:0]      inv_o [9],
  output logic                     singular_o,
  output logic                     saturated_o
);
  import smi_pkg::*;

  localparam int unsigned CW = 2 * D + 1;
  localparam int unsigned TW = 3 * D + 3;
  localparam int unsigned EW = CW + 1;

  logic                adv;
  logic                v_q [D+1];
  logic                z_q [D+1];
  logic signed [D-1:0] lq [NumCof];
  logic [NumCof-1:0]   lsat;
  logic signed [D-1:0] res_q [NumCof];
  logic                sat_q, zero_q;

  assign adv   = !out_valid_o || out_ready_i;
  assign pop_o = adv && q_valid_i;

  for (genvar k = 0; k < NumCof; k++) begin : g_lane
    smi_div #(.D(D), .F(F)) u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .c_mag_i(q_data_i[k*EW +: CW]),
      .c_neg_i(q_data_i[k*EW + CW]),
      .d_mag_i(q_data_i[NumCof*EW +: TW]),
      .d_neg_i(q_data_i[NumCof*EW + TW]),
      .q_o    (lq[k]),
      .sat_o  (lsat[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < D + 1; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= q_valid_i;
      for (int k = 1; k < D + 1; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      z_q[0] <= q_data_i[NumCof*EW + TW + 1];
      for (int k = 1; k < D + 1; k++) begin
        z_q[k] <= z_q[k-1];
      end
      for (int k = 0; k < NumCof; k++) begin
        res_q[k] <= z_q[D] ? '0 : lq[k];
      end
      sat_q  <= !z_q[D] && (|lsat);
      zero_q <= z_q[D];
    end
  end

  logic out_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v_q[D];
    end
  end

  assign out_valid_o = out_v_q;
  assign singular_o  = zero_q;
  assign saturated_o = sat_q;
  assign inv_o[0]    = res_q[0];
  assign inv_o[1]    = res_q[1];
  assign inv_o[2]    = res_q[2];
  assign inv_o[3]    = res_q[1];
  assign inv_o[4]    = res_q[3];
  assign inv_o[5]    = res_q[4];
  assign inv_o[6]    = res_q[2];
  assign inv_o[7]    = res_q[4];
  assign inv_o[8]    = res_q[5];
endmodule

[rtl/core/symmetric_3x3_matrix_inverse_core.sv]
// Top level of the symmetric 3x3 matrix inverse core.
// Takes one matrix per cycle and returns one inverse per cycle while neither half
// is stalled. An item passes through the cofactor and determinant front, a
// four-entry queue, and the six bit-serial pipelined divider lanes and the
// output register. The front stalls only when the queue is full; the back
// stalls only when the output is held.
module symmetric_3x3_matrix_inverse_core #(
  parameter int unsigned DATA_WIDTH = smi_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = smi_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] m00_i,
  input  logic signed [DATA_WIDTH-1:0] m01_i,
  input  logic signed [DATA_WIDTH-1:0] m02_i,
  input  logic signed [DATA_WIDTH-1:0] m10_i,
  input  logic signed [DATA_WIDTH-1:0] m11_i,
  input  logic signed [DATA_WIDTH-1:0] m12_i,
  input  logic signed [DATA_WIDTH-1:0] m20_i,
  input  logic signed [DATA_WIDTH-1:0] m21_i,
  input  logic signed [DATA_WIDTH-1:0] m22_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] inv00_o,
  output logic signed [DATA_WIDTH-1:0] inv01_o,
  output logic signed [DATA_WIDTH-1:0] inv02_o,
  output logic signed [DATA_WIDTH-1:0] inv10_o,
  output logic signed [DATA_WIDTH-1:0] inv11_o,
  output logic signed [DATA_WIDTH-1:0] inv12_o,
  output logic signed [DATA_WIDTH-1:0] inv20_o,
  output logic signed [DATA_WIDTH-1:0] inv21_o,
  output logic signed [DATA_WIDTH-1:0] inv22_o,
  output logic                         singular_o,
  output logic                         saturated_o
);
  import smi_pkg::*;

  localparam int unsigned QW = 6 * (2 * DATA_WIDTH + 2) + 3 * DATA_WIDTH + 5;

  logic signed [DATA_WIDTH-1:0] m [NumEnt];
  logic signed [DATA_WIDTH-1:0] inv [NumEnt];
  logic          push, full, pop, qv;
  logic [QW-1:0] fdata, qdata;

  assign m = '{m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i};

  smi_front #(.D(DATA_WIDTH)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .m_i       (m),
    .full_i    (full),
    .push_o    (push),
    .data_o    (fdata)
  );

  smi_fifo #(.Width(QW), .Depth(QueueDepth)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (fdata),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(qv),
    .data_o (qdata)
  );

  smi_back #(.D(DATA_WIDTH), .F(FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (qv),
    .q_data_i   (qdata),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .inv_o      (inv),
    .singular_o (singular_o),
    .saturated_o(saturated_o)
  );

  assign inv00_o = inv[0];
  assign inv01_o = inv[1];
  assign inv02_o = inv[2];
  assign inv10_o = inv[3];
  assign inv11_o = inv[4];
  assign inv12_o = inv[5];
  assign inv20_o = inv[6];
  assign inv21_o = inv[7];
  assign inv22_o = inv[8];
endmodule

[rtl/core/smi_checker.sv]
// Port-level assertions for the symmetric 3x3 matrix inverse core.
module smi_checker #(
  parameter int unsigned DATA_WIDTH = smi_pkg::DataWidthDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] inv00_o,
  input logic [DATA_WIDTH-1:0] inv01_o,
  input logic [DATA_WIDTH-1:0] inv02_o,
  input logic [DATA_WIDTH-1:0] inv10_o,
  input logic [DATA_WIDTH-1:0] inv11_o,
  input logic [DATA_WIDTH-1:0] inv12_o,
  input logic [DATA_WIDTH-1:0] inv20_o,
  input logic [DATA_WIDTH-1:0] inv21_o,
  input logic [DATA_WIDTH-1:0] inv22_o,
  input logic                  singular_o,
  input logic                  saturated_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(inv00_o))
    else $error("Stalled result item changed.");

  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inv01_o == inv10_o && inv02_o == inv20_o && inv12_o == inv21_o)
    else $error("Mirrored inverse entries differ.");

  a_singular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> !saturated_o && inv00_o == '0 && inv11_o == '0
      && inv22_o == '0 && inv01_o == '0 && inv02_o == '0 && inv12_o == '0)
    else $error("Singular item has nonzero entries or a saturation flag.");
endmodule

bind symmetric_3x3_matrix_inverse_core smi_checker #(.DATA_WIDTH(DATA_WIDTH)) u_smi_checker (.*);
